### hdl/bod_pkg.sv
// shared types, codes and constants of the ber object identifier decoder
`default_nettype none
package bod_pkg;

    // input word: one encoded byte of the object
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [31:0] avail_length;
    } t_in_word;

    // result word: one component or one error
    typedef struct packed {
        logic [31:0] component;
        logic [6:0]  component_index;
        logic        is_component;
        logic        last;
        logic [3:0]  error_code;
    } t_out_word;

    // results made by one input word, word0 first
    typedef struct packed {
        logic [1:0] count;
        t_out_word  word0;
        t_out_word  word1;
    } t_step_res;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMPONENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBID_CEIL     = 2'd1;

    // error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_SHORT      = 4'd1;
    localparam logic [3:0] ERR_WRONG_TAG  = 4'd2;
    localparam logic [3:0] ERR_INDEFINITE = 4'd3;
    localparam logic [3:0] ERR_LEN_LONG   = 4'd4;
    localparam logic [3:0] ERR_LEN_AVAIL  = 4'd5;
    localparam logic [3:0] ERR_SYNTAX     = 4'd6;
    localparam logic [3:0] ERR_TOO_LARGE  = 4'd7;
    localparam logic [3:0] ERR_TOO_MANY   = 4'd8;

    // format constants
    localparam logic [7:0]  OID_TAG          = 8'h06;
    localparam logic [7:0]  MAX_COMP_LIMIT   = 8'd128;
    localparam logic [7:0]  MIN_COMP         = 8'd2;
    localparam logic [6:0]  MAX_LEN_BYTES    = 7'd8;
    localparam logic [3:0]  LONG_LEN_TOP     = 4'd8;
    localparam logic [32:0] CL_MAX           = 33'h1_FFFF_FFFF;
    localparam logic [32:0] CL_SHIFT_LIM     = 33'h0_01FF_FFFF;
    localparam logic [31:0] ACC_SHIFT_LIM    = 32'h01FF_FFFF;
    localparam logic [31:0] ARC_SPLIT_1      = 32'd40;
    localparam logic [31:0] ARC_SPLIT_2      = 32'd80;

    // error result word
    function automatic t_out_word err_word(input logic [3:0] code);
        t_out_word w;
        w.component       = '0;
        w.component_index = '0;
        w.is_component    = 1'b0;
        w.last            = 1'b1;
        w.error_code      = code;
        return w;
    endfunction

    // component result word
    function automatic t_out_word comp_word(input logic [31:0] val,
                                            input logic [6:0] idx,
                                            input logic fin);
        t_out_word w;
        w.component       = val;
        w.component_index = idx;
        w.is_component    = 1'b1;
        w.last            = fin;
        w.error_code      = ERR_NONE;
        return w;
    endfunction

endpackage
`default_nettype wire

### hdl/bod_step.sv
// parser state and per-byte decode step of the object identifier decoder
`default_nettype none
module bod_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire bod_pkg::t_in_word  i_word,
    input  wire logic [7:0]         i_max_components,
    input  wire logic [31:0]        i_subid_ceil,
    output bod_pkg::t_step_res      o_res
);

    // phase codes
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_LEN_FIRST = 2'd1;
    localparam logic [1:0] PH_LEN_LONG  = 2'd2;
    localparam logic [1:0] PH_CONTENT   = 2'd3;

    logic [1:0]  r_phase,  n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [32:0] r_cl,     n_cl;
    logic [31:0] r_avail,  n_avail;
    logic [31:0] r_acc,    n_acc;
    logic        r_ovf,    n_ovf;
    logic [7:0]  r_cnt,    n_cnt;
    logic        r_first,  n_first;

    // decode of the current byte against the state
    always_comb begin
        logic [7:0]  b;
        logic [6:0]  n_len;
        logic [7:0]  cap;
        logic        do_begin;
        logic [32:0] cl_begin;
        logic [32:0] cl_next;
        logic [31:0] acc_next;
        logic        ovf_next;
        logic [31:0] v;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        fin;

        b        = i_word.data_byte;
        n_len    = b[6:0];
        do_begin = 1'b0;
        cl_begin = '0;
        cl_next  = '0;
        acc_next = '0;
        ovf_next = 1'b0;
        v        = '0;
        hi       = '0;
        lo       = '0;
        fin      = 1'b0;

        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_cl       = r_cl;
        n_avail    = r_avail;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_cnt      = r_cnt;
        n_first    = r_first;

        o_res.count = 2'd0;
        o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_NONE);
        o_res.word1 = bod_pkg::err_word(bod_pkg::ERR_NONE);

        // effective component capacity
        if (i_max_components < bod_pkg::MIN_COMP) begin
            cap = bod_pkg::MIN_COMP;
        end else if (i_max_components > bod_pkg::MAX_COMP_LIMIT) begin
            cap = bod_pkg::MAX_COMP_LIMIT;
        end else begin
            cap = i_max_components;
        end

        if (i_word.start_req) begin
            // tag byte
            if (i_word.avail_length < 32'd2) begin
                o_res.count = 2'd1;
                o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_SHORT);
                n_phase     = PH_IDLE;
            end else if (b != bod_pkg::OID_TAG) begin
                o_res.count = 2'd1;
                o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_WRONG_TAG);
                n_phase     = PH_IDLE;
            end else begin
                n_avail = i_word.avail_length - 32'd1;
                n_phase = PH_LEN_FIRST;
            end
        end else begin
            unique case (r_phase)
                PH_LEN_FIRST: begin
                    if (!b[7]) begin
                        // short form length
                        n_cl = {25'd0, b};
                        if ({24'd0, b} + 32'd1 > r_avail) begin
                            o_res.count = 2'd1;
                            o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_LEN_AVAIL);
                            n_phase     = PH_IDLE;
                        end else begin
                            do_begin = 1'b1;
                            cl_begin = {25'd0, b};
                        end
                    end else if (n_len == 7'd0) begin
                        o_res.count = 2'd1;
                        o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_INDEFINITE);
                        n_phase     = PH_IDLE;
                    end else if (n_len > bod_pkg::MAX_LEN_BYTES) begin
                        o_res.count = 2'd1;
                        o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_LEN_LONG);
                        n_phase     = PH_IDLE;
                    end else begin
                        // long form: count of length bytes
                        n_ovf      = r_avail < ({25'd0, n_len} + 32'd1);
                        n_avail    = n_ovf ? 32'd0 : r_avail - ({25'd0, n_len} + 32'd1);
                        n_cl       = '0;
                        n_len_left = n_len[3:0];
                        n_phase    = PH_LEN_LONG;
                    end
                end
                PH_LEN_LONG: begin
                    if (r_len_left == bod_pkg::LONG_LEN_TOP && b[7]) begin
                        o_res.count = 2'd1;
                        o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_LEN_LONG);
                        n_phase     = PH_IDLE;
                    end else begin
                        // saturating length accumulation
                        if (r_cl > bod_pkg::CL_SHIFT_LIM) begin
                            cl_next = bod_pkg::CL_MAX;
                        end else begin
                            cl_next = {r_cl[24:0], b};
                        end
                        n_cl       = cl_next;
                        n_len_left = r_len_left - 4'd1;
                        if (r_len_left == 4'd1) begin
                            if (r_ovf || cl_next > {1'b0, r_avail}) begin
                                o_res.count = 2'd1;
                                o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_LEN_AVAIL);
                                n_phase     = PH_IDLE;
                            end else begin
                                do_begin = 1'b1;
                                cl_begin = cl_next;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    if ({1'b0, r_cnt} + 9'd1 >= {1'b0, cap}) begin
                        o_res.count = 2'd1;
                        o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_TOO_MANY);
                        n_phase     = PH_IDLE;
                    end else begin
                        // base-128 subidentifier accumulation
                        ovf_next = r_ovf | (r_acc > bod_pkg::ACC_SHIFT_LIM);
                        acc_next = {r_acc[24:0], b[6:0]};
                        cl_next  = r_cl - 33'd1;
                        n_ovf    = ovf_next;
                        n_acc    = acc_next;
                        n_cl     = cl_next;
                        fin      = (cl_next == 33'd0);
                        if (b[7] && !fin) begin
                            n_phase = PH_CONTENT;
                        end else if (b[7]) begin
                            o_res.count = 2'd1;
                            o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_SYNTAX);
                            n_phase     = PH_IDLE;
                        end else if (ovf_next || acc_next > i_subid_ceil) begin
                            o_res.count = 2'd1;
                            o_res.word0 = bod_pkg::err_word(bod_pkg::ERR_TOO_LARGE);
                            n_phase     = PH_IDLE;
                        end else begin
                            v     = acc_next;
                            n_acc = '0;
                            if (fin) begin
                                n_phase = PH_IDLE;
                            end
                            if (!r_first) begin
                                // first subidentifier splits into two arcs
                                if (v < bod_pkg::ARC_SPLIT_1) begin
                                    hi = 32'd0;
                                    lo = v;
                                end else if (v < bod_pkg::ARC_SPLIT_2) begin
                                    hi = 32'd1;
                                    lo = v - bod_pkg::ARC_SPLIT_1;
                                end else begin
                                    hi = 32'd2;
                                    lo = v - bod_pkg::ARC_SPLIT_2;
                                end
                                n_first     = 1'b1;
                                n_cnt       = 8'd1;
                                o_res.count = 2'd2;
                                o_res.word0 = bod_pkg::comp_word(hi, 7'd0, 1'b0);
                                o_res.word1 = bod_pkg::comp_word(lo, 7'd1, fin);
                            end else begin
                                o_res.count = 2'd1;
                                o_res.word0 = bod_pkg::comp_word(v, r_cnt[6:0] + 7'd1, fin);
                                n_cnt       = r_cnt + 8'd1;
                            end
                        end
                    end
                end
                default: begin
                    // idle: stray bytes are dropped
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // start of content
        if (do_begin) begin
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_cnt   = '0;
            n_first = 1'b0;
            if (cl_begin == 33'd0) begin
                o_res.count = 2'd1;
                o_res.word0 = bod_pkg::comp_word(32'd0, 7'd0, 1'b1);
                n_phase     = PH_IDLE;
            end else begin
                n_phase = PH_CONTENT;
            end
        end

        if (!i_en) begin
            o_res.count = 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_len_left <= '0;
            r_cl       <= '0;
            r_avail    <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_cnt      <= '0;
            r_first    <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_cl       <= n_cl;
            r_avail    <= n_avail;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_cnt      <= n_cnt;
            r_first    <= n_first;
        end
    end

endmodule
`default_nettype wire

### hdl/bod_out_fifo.sv
// four-entry result queue taking up to two words per cycle
`default_nettype none
module bod_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bod_pkg::t_step_res i_push,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output bod_pkg::t_out_word      o_word
);

    bod_pkg::t_out_word r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    // room for the largest burst of one step
    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_word  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    // pointer and fill arithmetic
    always_comb begin
        n_wp  = r_wp + i_push.count;
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'd0, pop};
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.word0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.word1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/ber_oid_decoder.sv
// top level of the ber object identifier decoder
// Usage:
//  - input channel (i_in_valid / o_in_ready / i_in_word) takes one encoded
//    byte per word; start_req marks the tag byte and carries avail_length
//  - output channel (o_out_valid / i_out_ready / o_out_word) gives component
//    words and a final word with last set; an error word ends an object
//    and the components already sent for it should be dropped
//  - configuration channel (i_cfg_valid / o_cfg_ready) writes the component
//    capacity (index 0) and the subidentifier ceiling (index 1); always
//    ready, write only when idle
// Timing:
//  - a byte is registered at acceptance and decoded in the next cycle if the
//    queue has room; its results are written into the queue and shown on
//    the output port from there
//  - one byte per cycle while the queue has room; the first subidentifier
//    of an object makes two words and the output port moves one word per
//    cycle, so a run of such bytes is paced by the output port
//  - results wait in a four-entry queue; the input stalls when fewer than
//    two entries are free, so a stalled receiver stops input and nothing
//    is lost
// Reset: synchronous, active low; parser goes idle, queue empties and the
//  registers return to 128 and all ones
`default_nettype none
module ber_oid_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire bod_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bod_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bod_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    logic               r_in_vld;
    bod_pkg::t_in_word  r_in_word;
    logic [7:0]         r_max_components;
    logic [31:0]        r_subid_ceil;
    logic               room;
    logic               fire;
    bod_pkg::t_step_res step_res;

    // step fires when the queue can take its results
    assign fire        = r_in_vld && room;
    assign o_in_ready  = !r_in_vld || fire;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_components <= bod_pkg::MAX_COMP_LIMIT;
            r_subid_ceil     <= '1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bod_pkg::CFG_MAX_COMPONENTS) begin
                r_max_components <= i_cfg_data[7:0];
            end else if (i_cfg_index == bod_pkg::CFG_SUBID_CEIL) begin
                r_subid_ceil <= i_cfg_data;
            end
        end
    end

    // decode step
    bod_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (fire),
        .i_word           (r_in_word),
        .i_max_components (r_max_components),
        .i_subid_ceil     (r_subid_ceil),
        .o_res            (step_res)
    );

    // result queue
    bod_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
`default_nettype wire

### bench/tb_top.sv
// testbench of the ber object identifier decoder: directed and random objects checked word by word
`default_nettype none
module tb_top;

    localparam int RUN_LIMIT = 400000;
    localparam int RANDOM_BYTES = 175;
    localparam int CALM_BYTES = 150;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_LEN_FIRST,
        DEC_LEN_LONG,
        DEC_CONTENT
    } t_dec_phase;

    // clock, reset and block inputs
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    bod_pkg::t_in_word i_in_word = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [bod_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    bod_pkg::t_out_word o_out_word;
    logic o_cfg_ready;

    // decoder image kept by the bench
    t_dec_phase dec_phase = DEC_IDLE;
    logic [3:0] len_left = '0;
    logic [32:0] content_left = '0;
    logic [31:0] avail_left = '0;
    logic [31:0] acc = '0;
    logic acc_ovf = 1'b0;
    int unsigned comp_cnt = 0;
    logic pair_done = 1'b0;
    logic [7:0] cfg_max_comp = 8'd128;
    logic [31:0] cfg_subid_ceil = 32'hFFFF_FFFF;

    // words the decoder still owes, oldest first
    bod_pkg::t_out_word oid_words_due[$];

    // object under construction
    logic [7:0] content_q[$];
    logic [7:0] obj_q[$];

    bit calm = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int words_checked = 0;
    int bytes_used = 0;
    int objects_sent = 0;

    ber_oid_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles, %0d words still due", cycle_count,
                 oid_words_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    function automatic bod_pkg::t_out_word oid_word(input logic [31:0] val,
                                                    input logic [6:0] idx,
                                                    input logic comp, input logic fin,
                                                    input logic [3:0] code);
        bod_pkg::t_out_word w;
        w.component = val;
        w.component_index = idx;
        w.is_component = comp;
        w.last = fin;
        w.error_code = code;
        return w;
    endfunction

    // an error word ends the object
    task automatic oid_fail(input logic [3:0] code);
        dec_phase = DEC_IDLE;
        oid_words_due.push_back(oid_word('0, '0, 1'b0, 1'b1, code));
    endtask

    // length known: start on the content
    task automatic open_content();
        acc = '0;
        acc_ovf = 1'b0;
        comp_cnt = 0;
        pair_done = 1'b0;
        if (content_left == '0) begin
            dec_phase = DEC_IDLE;
            oid_words_due.push_back(oid_word('0, '0, 1'b1, 1'b1, bod_pkg::ERR_NONE));
        end else begin
            dec_phase = DEC_CONTENT;
        end
    endtask

    // advance the decoder image by one accepted byte and queue its words
    task automatic predict_byte(input bod_pkg::t_in_word w, output bit used);
        logic [7:0] b;
        logic [6:0] nlen;
        logic [31:0] v;
        logic [31:0] hi;
        logic [31:0] lo;
        logic fin;
        int unsigned cap;
        b = w.data_byte;
        used = 1'b1;
        if (w.start_req) begin
            if (w.avail_length < 32'd2) begin
                oid_fail(bod_pkg::ERR_SHORT);
            end else if (b != bod_pkg::OID_TAG) begin
                oid_fail(bod_pkg::ERR_WRONG_TAG);
            end else begin
                avail_left = w.avail_length - 32'd1;
                dec_phase = DEC_LEN_FIRST;
            end
        end else begin
            case (dec_phase)
                DEC_IDLE: begin
                    used = 1'b0;
                end
                DEC_LEN_FIRST: begin
                    if (!b[7]) begin
                        content_left = {25'd0, b};
                        if ({25'd0, b} + 33'd1 > {1'b0, avail_left}) begin
                            oid_fail(bod_pkg::ERR_LEN_AVAIL);
                        end else begin
                            open_content();
                        end
                    end else begin
                        nlen = b[6:0];
                        if (nlen == 7'd0) begin
                            oid_fail(bod_pkg::ERR_INDEFINITE);
                        end else if (nlen > 7'd8) begin
                            oid_fail(bod_pkg::ERR_LEN_LONG);
                        end else begin
                            // flag length bytes that already run past the buffer
                            acc_ovf = {1'b0, avail_left} < {26'd0, nlen} + 33'd1;
                            avail_left = acc_ovf ? 32'd0 : avail_left - ({25'd0, nlen} + 32'd1);
                            content_left = '0;
                            len_left = nlen[3:0];
                            dec_phase = DEC_LEN_LONG;
                        end
                    end
                end
                DEC_LEN_LONG: begin
                    if (len_left == 4'd8 && b[7]) begin
                        oid_fail(bod_pkg::ERR_LEN_LONG);
                    end else begin
                        // length saturates instead of wrapping
                        if (content_left > 33'h0_01FF_FFFF) begin
                            content_left = 33'h1_FFFF_FFFF;
                        end else begin
                            content_left = {content_left[24:0], b};
                        end
                        len_left = len_left - 4'd1;
                        if (len_left == 4'd0) begin
                            if (acc_ovf || content_left > {1'b0, avail_left}) begin
                                oid_fail(bod_pkg::ERR_LEN_AVAIL);
                            end else begin
                                open_content();
                            end
                        end
                    end
                end
                default: begin
                    cap = (cfg_max_comp < 8'd2) ? 2 : (cfg_max_comp > 8'd128) ? 128 : cfg_max_comp;
                    if (comp_cnt + 1 >= cap) begin
                        oid_fail(bod_pkg::ERR_TOO_MANY);
                    end else begin
                        if (acc > 32'h01FF_FFFF) begin
                            acc_ovf = 1'b1;
                        end
                        acc = {acc[24:0], b[6:0]};
                        content_left = content_left - 33'd1;
                        if (b[7] && content_left != '0) begin
                            // subidentifier continues
                        end else if (b[7]) begin
                            oid_fail(bod_pkg::ERR_SYNTAX);
                        end else if (acc_ovf || acc > cfg_subid_ceil) begin
                            oid_fail(bod_pkg::ERR_TOO_LARGE);
                        end else begin
                            v = acc;
                            acc = '0;
                            fin = (content_left == '0);
                            if (fin) begin
                                dec_phase = DEC_IDLE;
                            end
                            if (!pair_done) begin
                                // first subidentifier splits into the top two arcs
                                if (v < 32'd40) begin
                                    hi = 32'd0;
                                    lo = v;
                                end else if (v < 32'd80) begin
                                    hi = 32'd1;
                                    lo = v - 32'd40;
                                end else begin
                                    hi = 32'd2;
                                    lo = v - 32'd80;
                                end
                                pair_done = 1'b1;
                                comp_cnt = 1;
                                oid_words_due.push_back(oid_word(hi, 7'd0, 1'b1, 1'b0,
                                                                 bod_pkg::ERR_NONE));
                                oid_words_due.push_back(oid_word(lo, 7'd1, 1'b1, fin,
                                                                 bod_pkg::ERR_NONE));
                            end else begin
                                oid_words_due.push_back(oid_word(v, 7'(comp_cnt + 1), 1'b1, fin,
                                                                 bod_pkg::ERR_NONE));
                                comp_cnt = comp_cnt + 1;
                            end
                        end
                    end
                end
            endcase
        end
    endtask

    // send one byte word, idling at random first
    task automatic send_word(input logic [7:0] b, input logic s, input logic [31:0] a);
        bod_pkg::t_in_word w;
        bit used;
        w.data_byte = b;
        w.start_req = s;
        w.avail_length = a;
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_byte(w, used);
        if (used) begin
            bytes_used++;
        end
    endtask

    // send obj_q, tag word first
    task automatic send_frame(input logic [31:0] avail);
        int i;
        for (i = 0; i < obj_q.size(); i++) begin
            send_word(obj_q[i], i == 0, (i == 0) ? avail : $urandom());
        end
        objects_sent++;
    endtask

    // append one base-128 subidentifier to the content
    task automatic add_subid(input logic [63:0] v);
        int top;
        int k;
        top = 0;
        for (k = 0; k < 10; k++) begin
            if ((v >> (7 * k)) != 0) begin
                top = k;
            end
        end
        for (k = top; k >= 0; k--) begin
            content_q.push_back({k != 0, 7'(v >> (7 * k))});
        end
    endtask

    // tag, length (short form when nlen is 0 and it fits) and content into obj_q
    task automatic frame_object(input int nlen);
        longint len;
        int k;
        len = content_q.size();
        obj_q.delete();
        obj_q.push_back(bod_pkg::OID_TAG);
        if (nlen == 0 && len < 128) begin
            obj_q.push_back(8'(len));
        end else begin
            if (nlen == 0) begin
                nlen = 2;
            end
            obj_q.push_back(8'h80 | 8'(nlen));
            for (k = nlen - 1; k >= 0; k--) begin
                obj_q.push_back(8'(len >> (8 * k)));
            end
        end
        foreach (content_q[k]) begin
            obj_q.push_back(content_q[k]);
        end
    endtask

    task automatic send_built(input int nlen);
        frame_object(nlen);
        send_frame(obj_q.size());
    endtask

    // force the decoder idle, wait for every due word and let the pipeline drain
    task automatic settle_decoder();
        send_word(bod_pkg::OID_TAG, 1'b1, 32'd0);
        i_in_valid <= 1'b0;
        while (oid_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bod_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == bod_pkg::CFG_MAX_COMPONENTS) begin
            cfg_max_comp = data[7:0];
        end else if (idx == bod_pkg::CFG_SUBID_CEIL) begin
            cfg_subid_ceil = data;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_subid();
        case ($urandom_range(0, 9))
            0: return 64'($urandom_range(0, 127));
            1: return 64'hFFFF_FFFF;
            2: return 64'($urandom_range(0, 1100));
            3: return {$urandom(), $urandom()} >> $urandom_range(20, 63);
            default: return 64'($urandom() >> $urandom_range(0, 31));
        endcase
    endfunction

    // one random object, one in four broken somewhere
    task automatic random_object();
        int unsigned nsub;
        int unsigned nlen;
        int unsigned k;
        int unsigned cut;
        logic [31:0] avail;
        content_q.delete();
        nsub = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 5);
        for (k = 0; k < nsub; k++) begin
            add_subid(pick_subid());
        end
        nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        frame_object(nlen);
        case ($urandom_range(0, 3))
            0: avail = obj_q.size() + $urandom_range(1, 40);
            1: avail = $urandom() | obj_q.size();
            default: avail = obj_q.size();
        endcase
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 6))
                0: obj_q[0] = 8'($urandom());
                1: avail = $urandom_range(0, obj_q.size() - 1);
                2: begin
                    if (content_q.size() != 0) begin
                        obj_q[obj_q.size() - 1] = obj_q[obj_q.size() - 1] | 8'h80;
                    end
                end
                3: begin
                    cut = $urandom_range(1, obj_q.size() - 1);
                    while (obj_q.size() > cut) begin
                        void'(obj_q.pop_back());
                    end
                end
                4: begin
                    k = $urandom_range(1, obj_q.size() - 1);
                    obj_q[k] = 8'($urandom());
                end
                5: obj_q[1] = 8'($urandom_range(128, 255));
                default: begin
                    repeat ($urandom_range(1, 4)) send_word(8'($urandom()), 1'b0, $urandom());
                end
            endcase
        end
        send_frame(avail);
    endtask

    // well-formed identifiers, arc split, length forms, idle bytes, restart
    task automatic test_valid_forms();
        content_q = '{8'h2B, 8'h06, 8'h01, 8'h02, 8'h01};
        send_built(0);
        content_q.delete();
        send_built(0);
        content_q.delete();
        add_subid(39);
        add_subid(40);
        send_built(1);
        content_q.delete();
        add_subid(79);
        send_built(4);
        content_q.delete();
        add_subid(80);
        add_subid(32'hFFFF_FFFF);
        send_built(8);
        content_q.delete();
        add_subid(32'hFFFF_FFFF);
        frame_object(0);
        send_frame(32'hFFFF_FFFF);
        // bytes with no object open are dropped
        send_word(8'hA5, 1'b0, 32'hFFFF_FFFF);
        send_word(8'h5A, 1'b0, 32'h0);
        // a new tag abandons the object in flight
        obj_q = '{bod_pkg::OID_TAG, 8'h05, 8'h2B};
        send_frame(32'd7);
        content_q = '{8'h2B, 8'h06};
        frame_object(0);
        send_frame(32'd1000);
    endtask

    // each error code apart from too many components
    task automatic test_error_cases();
        obj_q = '{bod_pkg::OID_TAG};
        send_frame(32'd0);
        send_frame(32'd1);
        obj_q = '{8'h07, 8'h01, 8'h00};
        send_frame(32'd3);
        obj_q = '{bod_pkg::OID_TAG, 8'h80};
        send_frame(32'd10);
        obj_q = '{bod_pkg::OID_TAG, 8'h89};
        send_frame(32'd10);
        obj_q = '{bod_pkg::OID_TAG, 8'h88, 8'h80};
        send_frame(32'd20);
        obj_q = '{bod_pkg::OID_TAG, 8'h05, 8'h2B, 8'h06};
        send_frame(32'd4);
        // length bytes alone run past the buffer
        obj_q = '{bod_pkg::OID_TAG, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01};
        send_frame(32'd3);
        obj_q = '{bod_pkg::OID_TAG, 8'h82, 8'h01, 8'h00};
        send_frame(32'd10);
        // huge length saturates
        obj_q = '{bod_pkg::OID_TAG, 8'h88, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF};
        send_frame(32'hFFFF_FFFF);
        obj_q = '{bod_pkg::OID_TAG, 8'h02, 8'h2B, 8'h81};
        send_frame(32'd4);
        content_q.delete();
        add_subid(43);
        add_subid(64'h1_0000_0000);
        send_built(0);
        content_q.delete();
        add_subid(64'hFFFF_FFFF_FFFF_FFFF);
        send_built(0);
    endtask

    // component capacity at its extremes
    task automatic test_component_limit();
        int k;
        settle_decoder();
        write_reg(bod_pkg::CFG_MAX_COMPONENTS, 32'd2);
        content_q = '{8'h2B, 8'h06};
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_MAX_COMPONENTS, 32'd0);
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_MAX_COMPONENTS, 32'd3);
        content_q = '{8'h2B, 8'h06, 8'h01};
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_MAX_COMPONENTS, 32'd255);
        // 127 subidentifiers fill all 128 slots, one more overflows
        content_q.delete();
        for (k = 0; k < 127; k++) begin
            add_subid(k);
        end
        send_built(0);
        add_subid(5);
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_MAX_COMPONENTS, 32'd128);
        send_built(2);
    endtask

    // subidentifier ceiling at its extremes
    task automatic test_subid_limit();
        settle_decoder();
        write_reg(bod_pkg::CFG_SUBID_CEIL, 32'd0);
        content_q = '{8'h00};
        send_built(0);
        content_q = '{8'h01};
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_SUBID_CEIL, 32'd1000);
        content_q.delete();
        add_subid(1000);
        add_subid(999);
        send_built(0);
        content_q.delete();
        add_subid(40);
        add_subid(1001);
        send_built(0);
        settle_decoder();
        write_reg(bod_pkg::CFG_SUBID_CEIL, 32'hFFFF_FFFF);
    endtask

    // random objects under a sweep of register settings
    task automatic test_random_traffic();
        logic [7:0] comp_set[7];
        logic [31:0] subid_set[7];
        int p;
        int stop_at;
        comp_set = '{8'd128, 8'd2, 8'd0, 8'd255, 8'd5, 8'd3, 8'd128};
        subid_set = '{32'hFFFF_FFFF, $urandom(), 32'd0, 32'd1000, 32'hFFFF_FFFF,
                      $urandom() >> 8, 32'hFFFF_FFFF};
        for (p = 0; p < 7; p++) begin
            settle_decoder();
            write_reg(bod_pkg::CFG_MAX_COMPONENTS, {24'd0, comp_set[p]});
            write_reg(bod_pkg::CFG_SUBID_CEIL, subid_set[p]);
            stop_at = bytes_used + RANDOM_BYTES / 7;
            while (bytes_used < stop_at) begin
                random_object();
            end
        end
    endtask

    // back to back traffic with no idling on either side
    task automatic test_calm_stretch();
        int stop_at;
        calm = 1'b1;
        stop_at = bytes_used + CALM_BYTES;
        while (bytes_used < stop_at) begin
            random_object();
        end
        calm = 1'b0;
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin : result_check
        bod_pkg::t_out_word due;
        cycle_count <= cycle_count + 1;
        if (o_out_valid && i_out_ready) begin
            if (oid_words_due.size() == 0) begin
                report_mismatch($sformatf("word with nothing due: %p", o_out_word));
            end else begin
                due = oid_words_due.pop_front();
                if (o_out_word.component !== due.component) begin
                    report_mismatch($sformatf("word %0d component %0h, expected %0h",
                                              words_checked, o_out_word.component,
                                              due.component));
                end
                if (o_out_word.component_index !== due.component_index) begin
                    report_mismatch($sformatf("word %0d index %0d, expected %0d",
                                              words_checked, o_out_word.component_index,
                                              due.component_index));
                end
                if (o_out_word.is_component !== due.is_component) begin
                    report_mismatch($sformatf("word %0d is_component %0b, expected %0b",
                                              words_checked, o_out_word.is_component,
                                              due.is_component));
                end
                if (o_out_word.last !== due.last) begin
                    report_mismatch($sformatf("word %0d last %0b, expected %0b",
                                              words_checked, o_out_word.last, due.last));
                end
                if (o_out_word.error_code !== due.error_code) begin
                    report_mismatch($sformatf("word %0d error %0d, expected %0d",
                                              words_checked, o_out_word.error_code,
                                              due.error_code));
                end
            end
            words_checked++;
        end
        i_out_ready <= calm || ($urandom_range(99) >= 14);
    end

    // test sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_valid_forms();
        test_error_cases();
        test_component_limit();
        test_subid_limit();
        test_random_traffic();
        test_calm_stretch();
        settle_decoder();
        repeat (20) @(posedge i_clk);
        if (oid_words_due.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", oid_words_due.size()));
        end
        $display("sent %0d objects, %0d bytes decoded, %0d result words compared",
                 objects_sent, bytes_used, words_checked);
        $display("register sweep covered capacity 0 to 255 and subid ceiling 0 to all ones");
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
